>>> design/kvt_pkg.sv
// Shared types and codes for the key/value table with swap-remove.
package kvt_pkg;

  // Field widths of the request and result words
  localparam int OP_W    = 3;
  localparam int KEY_W   = 16;
  localparam int VALUE_W = 16;
  localparam int INDEX_W = 4;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // Request word
  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } req_t;

  // Result word
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value_out;
    logic [KEY_W-1:0]   key_out;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] entry_count;
    logic               full_res;
  } res_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_READ
  } state_t;

endpackage

>>> design/key_value_table_swap_remove.sv
// Top level of the dense key/value table with linear search and swap-remove.
//
//   channel   | ports                 | handshake
//   ----------+-----------------------+------------------------------------
//   request   | start, busy, request  | word taken when start && !busy
//   result    | done, result          | one word per request, one cycle wide
//
// Lookup, add and remove scan the live slots through the single RAM read
// port, one slot per cycle; a remove that hits then adds a last-entry move.
// Clear, unused codes and reads of empty slots finish straight from idle,
// and occupied reads pass through the read state.
// Reset clears the sequencer and the live count; RAM contents are left as
// they are. The result receiver cannot stall; busy holds off new requests.
module key_value_table_swap_remove #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  kvt_pkg::req_t request,
  output logic          done,
  output kvt_pkg::res_t result
);

  localparam int KW = (KEY_BITS < kvt_pkg::KEY_W) ? KEY_BITS : kvt_pkg::KEY_W;
  localparam int VW = (VALUE_BITS < kvt_pkg::VALUE_W) ? VALUE_BITS : kvt_pkg::VALUE_W;
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int DW = KW + VW;

  // registers
  kvt_pkg::state_t state, state_next;
  logic [CW-1:0]   live, live_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic            pend, pend_next;
  logic [AW-1:0]   pidx, pidx_next;
  kvt_pkg::req_t   req, req_next;
  kvt_pkg::res_t   res, res_next;
  logic            done_r, done_next;

  // RAM port signals
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;

  // decoded fields
  logic [KW-1:0] req_key_m, in_key_m, rd_key;
  logic [VW-1:0] req_val_m, rd_val;
  logic [31:0]   idx32;
  logic [CW-1:0] last;
  logic          found;
  logic          has_room;

  kvt_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req_key_m = req.key[KW-1:0];
  assign req_val_m = req.value[VW-1:0];
  assign in_key_m  = request.key[KW-1:0];
  assign rd_key    = rdata[DW-1:VW];
  assign rd_val    = rdata[VW-1:0];
  assign idx32     = 32'(request.index);
  assign last      = live - CW'(1);
  assign has_room  = live < CW'(ENTRIES);
  assign found     = (state == kvt_pkg::ST_SCAN) && pend && (rd_key == req_key_m);

  assign busy   = (state != kvt_pkg::ST_IDLE);
  assign done   = done_r;
  assign result = res;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= kvt_pkg::ST_IDLE;
      live   <= '0;
      pend   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      state  <= state_next;
      live   <= live_next;
      pend   <= pend_next;
      done_r <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt  <= cnt_next;
    pidx <= pidx_next;
    req  <= req_next;
    res  <= res_next;
  end

  // sequencer: next state, RAM control and result word
  always_comb begin
    state_next = state;
    live_next  = live;
    cnt_next   = cnt;
    pend_next  = pend;
    pidx_next  = pidx;
    req_next   = req;
    res_next   = res;
    done_next  = 1'b0;
    we         = 1'b0;
    waddr      = pidx;
    wdata      = rdata;
    raddr      = cnt[AW-1:0];

    case (state)
      kvt_pkg::ST_IDLE: begin
        raddr = idx32[AW-1:0];
        if (start) begin
          req_next             = request;
          res_next.hit         = 1'b0;
          res_next.value_out   = '0;
          res_next.key_out     = kvt_pkg::KEY_W'(in_key_m);
          res_next.slot        = '0;
          res_next.entry_count = kvt_pkg::COUNT_W'(live);
          res_next.full_res    = 1'b0;
          case (request.operation)
            kvt_pkg::OP_LOOKUP, kvt_pkg::OP_ADD, kvt_pkg::OP_REMOVE: begin
              cnt_next   = '0;
              pend_next  = 1'b0;
              state_next = kvt_pkg::ST_SCAN;
            end
            kvt_pkg::OP_CLEAR: begin
              live_next            = '0;
              res_next.entry_count = '0;
              done_next            = 1'b1;
            end
            kvt_pkg::OP_READ: begin
              res_next.slot = request.index;
              if (idx32 < 32'(live)) begin
                state_next = kvt_pkg::ST_READ;
              end else begin
                res_next.key_out = '0;
                done_next        = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      kvt_pkg::ST_SCAN: begin
        if (found) begin
          pend_next     = 1'b0;
          res_next.hit  = 1'b1;
          res_next.slot = kvt_pkg::SLOT_W'(pidx);
          case (req.operation)
            kvt_pkg::OP_ADD: begin
              we                 = 1'b1;
              waddr              = pidx;
              wdata              = {req_key_m, req_val_m};
              res_next.value_out = kvt_pkg::VALUE_W'(req_val_m);
              done_next          = 1'b1;
              state_next         = kvt_pkg::ST_IDLE;
            end
            kvt_pkg::OP_REMOVE: begin
              // fetch the last live entry to fill the freed slot
              raddr              = last[AW-1:0];
              res_next.value_out = kvt_pkg::VALUE_W'(rd_val);
              state_next         = kvt_pkg::ST_MOVE;
            end
            default: begin
              res_next.value_out = kvt_pkg::VALUE_W'(rd_val);
              done_next          = 1'b1;
              state_next         = kvt_pkg::ST_IDLE;
            end
          endcase
        end else if (cnt < live) begin
          // issue the next slot; its word is compared in the following cycle
          raddr     = cnt[AW-1:0];
          cnt_next  = cnt + CW'(1);
          pend_next = 1'b1;
          pidx_next = cnt[AW-1:0];
        end else begin
          // miss: every live slot compared
          pend_next  = 1'b0;
          done_next  = 1'b1;
          state_next = kvt_pkg::ST_IDLE;
          if (req.operation == kvt_pkg::OP_ADD) begin
            if (has_room) begin
              we                   = 1'b1;
              waddr                = live[AW-1:0];
              wdata                = {req_key_m, req_val_m};
              live_next            = live + CW'(1);
              res_next.value_out   = kvt_pkg::VALUE_W'(req_val_m);
              res_next.slot        = kvt_pkg::SLOT_W'(live);
              res_next.entry_count = kvt_pkg::COUNT_W'(live + CW'(1));
            end else begin
              res_next.full_res = 1'b1;
            end
          end
        end
      end

      kvt_pkg::ST_MOVE: begin
        // last entry now on the read port: write it into the freed slot
        we                   = 1'b1;
        waddr                = pidx;
        wdata                = rdata;
        live_next            = last;
        res_next.entry_count = kvt_pkg::COUNT_W'(last);
        done_next            = 1'b1;
        state_next           = kvt_pkg::ST_IDLE;
      end

      kvt_pkg::ST_READ: begin
        res_next.hit       = 1'b1;
        res_next.key_out   = kvt_pkg::KEY_W'(rd_key);
        res_next.value_out = kvt_pkg::VALUE_W'(rd_val);
        done_next          = 1'b1;
        state_next         = kvt_pkg::ST_IDLE;
      end

      default: begin
        state_next = kvt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/kvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
